>>> sv/kcl_pkg.sv
package kcl_pkg;

	// Internal lock state, one-hot
	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_ENTER   = 5'b00010,
		ST_ARMED   = 5'b00100,
		ST_NEWCODE = 5'b01000,
		ST_SHOW    = 5'b10000
	} lock_fsm_t;

	// Mode codes on the result port
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_ENTER   = 3'd1;
	localparam logic [2:0] MODE_ARMED   = 3'd2;
	localparam logic [2:0] MODE_NEWCODE = 3'd3;
	localparam logic [2:0] MODE_SHOW    = 3'd4;

	// Message codes
	localparam logic [2:0] MSG_NONE    = 3'd0;
	localparam logic [2:0] MSG_OK      = 3'd1;
	localparam logic [2:0] MSG_WRONG   = 3'd2;
	localparam logic [2:0] MSG_BADLEN  = 3'd3;
	localparam logic [2:0] MSG_SAVED   = 3'd4;
	localparam logic [2:0] MSG_CHANGE  = 3'd5;
	localparam logic [2:0] MSG_NEWCODE = 3'd6;
	localparam logic [2:0] MSG_ENTER   = 3'd7;

	// Item kinds
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// ASCII keys
	localparam logic [7:0] KEY_HASH = 8'h23;
	localparam logic [7:0] KEY_STAR = 8'h2A;
	localparam logic [7:0] KEY_ZERO = 8'h30;
	localparam logic [7:0] KEY_NINE = 8'h39;

	// Configuration register indexes
	localparam logic [1:0] REG_REPEAT_GUARD = 2'd0;
	localparam logic [1:0] REG_SHORT_HOLD   = 2'd1;
	localparam logic [1:0] REG_LONG_HOLD    = 2'd2;
	localparam logic [1:0] REG_MIN_LENGTH   = 2'd3;

	// Configuration reset values
	localparam logic [15:0] RST_REPEAT_GUARD = 16'd200;
	localparam logic [15:0] RST_SHORT_HOLD   = 16'd1000;
	localparam logic [15:0] RST_LONG_HOLD    = 16'd1500;
	localparam logic [3:0]  RST_MIN_LENGTH   = 4'd8;

	// Factory code: digits 1 to 8
	localparam int FACTORY_LENGTH = 8;

	function automatic logic [2:0] mode_code(lock_fsm_t st);
		logic [2:0] m;
		case (st)
			ST_IDLE:    m = MODE_IDLE;
			ST_ENTER:   m = MODE_ENTER;
			ST_ARMED:   m = MODE_ARMED;
			ST_NEWCODE: m = MODE_NEWCODE;
			ST_SHOW:    m = MODE_SHOW;
			default:    m = MODE_IDLE;
		endcase
		return m;
	endfunction

endpackage

>>> sv/keypad_code_lock.sv
// Keypad code lock: an input transaction passes the input register, then the state update and
// the result register; throughput is one transaction per cycle while out_stall does not hold it.
// The whole update, including the parallel compare of all code digits, fits between the
// stage-1 register and the result register, so a new item enters every cycle unless stalled.
// Reset (arst_n low, asynchronous) returns to idle with the factory code 1..8, empty entry,
// default configuration and empty pipeline; the entry buffer itself is not cleared.
module keypad_code_lock #(
	parameter int MAX_CODE_DIGITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  key_code,
	input  logic [31:0] now_ms,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  mode,
	output logic [2:0]  message,
	output logic [3:0]  digits_entered,
	output logic        key_accepted,
	output logic        back_to_idle
);

	// Width of a digit count (0..MAX) and of a digit index (0..MAX-1)
	localparam int LEN_W = $clog2(MAX_CODE_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_CODE_DIGITS);
	// Common width for comparing a count with the 4-bit minimum length
	localparam int CMP_W = (LEN_W > 4) ? LEN_W : 4;
	localparam int RST_CODE_LEN =
		(MAX_CODE_DIGITS < kcl_pkg::FACTORY_LENGTH) ? MAX_CODE_DIGITS : kcl_pkg::FACTORY_LENGTH;

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken
	// ------------------------------------------------------------------
	logic [15:0] repeat_guard_q;
	logic [15:0] short_hold_q;
	logic [15:0] long_hold_q;
	logic [3:0]  min_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_guard_q <= kcl_pkg::RST_REPEAT_GUARD;
			short_hold_q   <= kcl_pkg::RST_SHORT_HOLD;
			long_hold_q    <= kcl_pkg::RST_LONG_HOLD;
			min_len_q      <= kcl_pkg::RST_MIN_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kcl_pkg::REG_REPEAT_GUARD: repeat_guard_q <= cfg_data;
				kcl_pkg::REG_SHORT_HOLD:   short_hold_q   <= cfg_data;
				kcl_pkg::REG_LONG_HOLD:    long_hold_q    <= cfg_data;
				kcl_pkg::REG_MIN_LENGTH:   min_len_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: stage 1 holds the accepted transaction, the
	// result register holds the finished result until it is taken.
	// ------------------------------------------------------------------
	logic        v_s1;
	logic        op_s1;
	logic [7:0]  key_s1;
	logic [31:0] now_s1;
	logic        out_valid_q;
	logic        advance;
	logic        fire;

	// Move stage 1 forward whenever the result slot is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = v_s1 && advance;
	assign in_stall = v_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	// Payload of stage 1: load on every accepted transaction
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= op;
			key_s1 <= key_code;
			now_s1 <= now_ms;
		end
	end

	// ------------------------------------------------------------------
	// Lock state
	// ------------------------------------------------------------------
	kcl_pkg::lock_fsm_t state_q, state_n;
	logic [2:0]       shown_msg_q, shown_msg_n;
	logic [LEN_W-1:0] entry_len_q, entry_len_n;
	logic [LEN_W-1:0] code_len_q, code_len_n;
	logic [15:0]      hold_q, hold_n;
	logic [7:0]       prev_key_q, prev_key_n;
	logic [31:0]      prev_time_q, prev_time_n;
	logic [3:0]       entry_q [MAX_CODE_DIGITS];
	logic [3:0]       code_q  [MAX_CODE_DIGITS];

	logic             entry_we;
	logic [IDX_W-1:0] entry_wa;
	logic             code_we;
	logic             accepted;
	logic             expired;
	logic             guard_hit;
	logic [31:0]      elapsed;
	logic             entry_match;
	logic             is_digit;
	logic             len_bad;
	logic [2:0]       msg_n;

	// Time since the last accepted key, modulo 2^32
	assign elapsed   = now_s1 - prev_time_q;
	assign guard_hit = (key_s1 == prev_key_q) && (elapsed < {16'd0, repeat_guard_q});

	// Compare the entry with the stored code, all positions at once
	always_comb begin
		entry_match = (entry_len_q == code_len_q);
		for (int i = 0; i < MAX_CODE_DIGITS; i++) begin
			if ((LEN_W'(i) < entry_len_q) && (entry_q[i] != code_q[i]))
				entry_match = 1'b0;
		end
	end

	always_comb begin
		is_digit = key_s1 inside {[kcl_pkg::KEY_ZERO : kcl_pkg::KEY_NINE]};
	end

	assign len_bad = (CMP_W'(entry_len_q) < CMP_W'(min_len_q))
		|| (entry_len_q > LEN_W'(MAX_CODE_DIGITS));

	// Next-state logic for one transaction
	always_comb begin
		state_n     = state_q;
		shown_msg_n = shown_msg_q;
		entry_len_n = entry_len_q;
		code_len_n  = code_len_q;
		hold_n      = hold_q;
		prev_key_n  = prev_key_q;
		prev_time_n = prev_time_q;
		entry_we    = 1'b0;
		entry_wa    = entry_len_q[IDX_W-1:0];
		code_we     = 1'b0;
		accepted    = 1'b0;
		expired     = 1'b0;

		if (op_s1 == kcl_pkg::OP_KEY) begin
			if (!guard_hit) begin
				accepted    = 1'b1;
				prev_key_n  = key_s1;
				prev_time_n = now_s1;
				if (state_q != kcl_pkg::ST_SHOW) begin
					if (key_s1 == kcl_pkg::KEY_HASH) begin
						state_n = kcl_pkg::ST_ARMED;
					end else if (key_s1 == kcl_pkg::KEY_STAR) begin
						case (state_q)
							kcl_pkg::ST_ENTER: begin
								state_n     = kcl_pkg::ST_SHOW;
								entry_len_n = '0;
								if (entry_match) begin
									shown_msg_n = kcl_pkg::MSG_OK;
									hold_n      = short_hold_q;
								end else begin
									shown_msg_n = kcl_pkg::MSG_WRONG;
									hold_n      = long_hold_q;
								end
							end
							kcl_pkg::ST_ARMED: begin
								state_n     = kcl_pkg::ST_NEWCODE;
								entry_len_n = '0;
							end
							kcl_pkg::ST_NEWCODE: begin
								state_n     = kcl_pkg::ST_SHOW;
								entry_len_n = '0;
								if (len_bad) begin
									shown_msg_n = kcl_pkg::MSG_BADLEN;
									hold_n      = long_hold_q;
								end else begin
									code_we     = 1'b1;
									code_len_n  = entry_len_q;
									shown_msg_n = kcl_pkg::MSG_SAVED;
									hold_n      = short_hold_q;
								end
							end
							default: ;
						endcase
					end else if (is_digit) begin
						// A digit in idle opens a fresh entry
						if (state_q == kcl_pkg::ST_IDLE) begin
							state_n     = kcl_pkg::ST_ENTER;
							entry_len_n = '0;
						end
						// Append unless armed or the buffer is full
						if ((state_n == kcl_pkg::ST_ENTER || state_n == kcl_pkg::ST_NEWCODE)
							&& (entry_len_n < LEN_W'(MAX_CODE_DIGITS))) begin
							entry_we    = 1'b1;
							entry_wa    = entry_len_n[IDX_W-1:0];
							entry_len_n = entry_len_n + 1'b1;
						end
					end
				end
			end
		end else if (state_q == kcl_pkg::ST_SHOW) begin
			// Count the hold down; one more tick at zero ends the message
			if (hold_q != 16'd0) begin
				hold_n = hold_q - 16'd1;
			end else begin
				state_n = kcl_pkg::ST_IDLE;
				expired = 1'b1;
			end
		end

		case (state_n)
			kcl_pkg::ST_SHOW:    msg_n = shown_msg_n;
			kcl_pkg::ST_ARMED:   msg_n = kcl_pkg::MSG_CHANGE;
			kcl_pkg::ST_NEWCODE: msg_n = kcl_pkg::MSG_NEWCODE;
			default:             msg_n = kcl_pkg::MSG_ENTER;
		endcase
	end

	// Control state and stored code: commit on each processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kcl_pkg::ST_IDLE;
			shown_msg_q <= kcl_pkg::MSG_NONE;
			entry_len_q <= '0;
			code_len_q  <= LEN_W'(RST_CODE_LEN);
			hold_q      <= '0;
			prev_key_q  <= '0;
			prev_time_q <= '0;
			for (int i = 0; i < MAX_CODE_DIGITS; i++)
				code_q[i] <= (i < kcl_pkg::FACTORY_LENGTH) ? 4'(i + 1) : 4'd0;
		end else if (fire) begin
			state_q     <= state_n;
			shown_msg_q <= shown_msg_n;
			entry_len_q <= entry_len_n;
			code_len_q  <= code_len_n;
			hold_q      <= hold_n;
			prev_key_q  <= prev_key_n;
			prev_time_q <= prev_time_n;
			if (code_we) begin
				for (int i = 0; i < MAX_CODE_DIGITS; i++)
					code_q[i] <= entry_q[i];
			end
		end
	end

	// Entry buffer: no reset, only written positions are ever compared
	always_ff @(posedge clk) begin
		if (fire && entry_we)
			entry_q[entry_wa] <= key_s1[3:0];
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic [2:0] mode_q;
	logic [2:0] msg_q;
	logic [3:0] digits_q;
	logic       acc_q;
	logic       exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mode_q   <= kcl_pkg::mode_code(state_n);
			msg_q    <= msg_n;
			digits_q <= 4'(entry_len_n);
			acc_q    <= accepted;
			exp_q    <= expired;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode           = mode_q;
	assign message        = msg_q;
	assign digits_entered = digits_q;
	assign key_accepted   = acc_q;
	assign back_to_idle   = exp_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_entry_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_len_q <= LEN_W'(MAX_CODE_DIGITS))
		else $error("entry length beyond buffer depth");

	a_show_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && mode_q == kcl_pkg::MODE_SHOW) |->
		(msg_q == kcl_pkg::MSG_OK || msg_q == kcl_pkg::MSG_WRONG
		|| msg_q == kcl_pkg::MSG_BADLEN || msg_q == kcl_pkg::MSG_SAVED))
		else $error("message mode without an outcome message");

	a_expire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && exp_q) |-> (mode_q == kcl_pkg::MODE_IDLE && !acc_q))
		else $error("hold expiry without return to idle");

	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == kcl_pkg::OP_TICK && state_q == kcl_pkg::ST_SHOW && hold_q != 16'd0)
		|=> (hold_q == $past(hold_q) - 16'd1))
		else $error("hold count did not step down on a tick");

endmodule

>>> tb/sv/keypad_lock_checker.sv
module keypad_lock_checker #(
	parameter int MAX_CODE_DIGITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [7:0]  key_code,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  mode,
	input  logic [2:0]  message,
	input  logic [3:0]  digits_entered,
	input  logic        key_accepted,
	input  logic        back_to_idle,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] message;
		logic [3:0] digits;
		logic       accepted;
		logic       expired;
	} lock_view_t;

	lock_view_t predicted_views[$];
	lock_view_t oldest_view;

	// shadow copy of the lock
	logic [2:0]  lock_mode;
	logic [2:0]  shown_msg;
	logic [3:0]  entry_digits [MAX_CODE_DIGITS];
	int          entry_len;
	logic [3:0]  code_digits [MAX_CODE_DIGITS];
	int          code_len;
	logic [15:0] hold_left;
	logic [7:0]  prev_press;
	logic [31:0] prev_press_ms;

	// shadow configuration
	logic [15:0] guard_ms;
	logic [15:0] short_hold;
	logic [15:0] long_hold;
	logic [3:0]  min_len;

	function automatic void reset_lock();
		guard_ms   = kcl_pkg::RST_REPEAT_GUARD;
		short_hold = kcl_pkg::RST_SHORT_HOLD;
		long_hold  = kcl_pkg::RST_LONG_HOLD;
		min_len    = kcl_pkg::RST_MIN_LENGTH;
		lock_mode  = kcl_pkg::MODE_IDLE;
		shown_msg  = kcl_pkg::MSG_NONE;
		entry_len  = 0;
		for (int i = 0; i < MAX_CODE_DIGITS; i++) begin
			entry_digits[i] = '0;
			code_digits[i]  = (i < kcl_pkg::FACTORY_LENGTH) ? 4'(i + 1) : '0;
		end
		code_len      = kcl_pkg::FACTORY_LENGTH;
		hold_left     = '0;
		prev_press    = '0;
		prev_press_ms = '0;
	endfunction

	function automatic void show_message(logic [2:0] msg, logic [15:0] hold);
		shown_msg = msg;
		hold_left = hold;
		lock_mode = kcl_pkg::MODE_SHOW;
	endfunction

	function automatic bit entry_is_code();
		if (entry_len != code_len)
			return 1'b0;
		for (int i = 0; i < entry_len && i < MAX_CODE_DIGITS; i++)
			if (entry_digits[i] != code_digits[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void apply_key(logic [7:0] key);
		if (lock_mode == kcl_pkg::MODE_SHOW)
			return;
		if (key == kcl_pkg::KEY_HASH) begin
			lock_mode = kcl_pkg::MODE_ARMED;
			return;
		end
		if (key == kcl_pkg::KEY_STAR) begin
			case (lock_mode)
				kcl_pkg::MODE_ENTER: begin
					if (entry_is_code())
						show_message(kcl_pkg::MSG_OK, short_hold);
					else
						show_message(kcl_pkg::MSG_WRONG, long_hold);
					entry_len = 0;
				end
				kcl_pkg::MODE_ARMED: begin
					lock_mode = kcl_pkg::MODE_NEWCODE;
					entry_len = 0;
				end
				kcl_pkg::MODE_NEWCODE: begin
					if (entry_len < min_len || entry_len > MAX_CODE_DIGITS) begin
						show_message(kcl_pkg::MSG_BADLEN, long_hold);
					end else begin
						code_digits = entry_digits;
						code_len    = entry_len;
						show_message(kcl_pkg::MSG_SAVED, short_hold);
					end
					entry_len = 0;
				end
				default: ;
			endcase
			return;
		end
		if (key >= kcl_pkg::KEY_ZERO && key <= kcl_pkg::KEY_NINE) begin
			if (lock_mode == kcl_pkg::MODE_IDLE) begin
				lock_mode = kcl_pkg::MODE_ENTER;
				entry_len = 0;
			end
			if ((lock_mode == kcl_pkg::MODE_ENTER || lock_mode == kcl_pkg::MODE_NEWCODE) &&
					entry_len < MAX_CODE_DIGITS) begin
				entry_digits[entry_len] = 4'(key - kcl_pkg::KEY_ZERO);
				entry_len++;
			end
		end
	endfunction

	function automatic lock_view_t advance_lock(logic kind, logic [7:0] key, logic [31:0] stamp);
		lock_view_t view;
		logic [31:0] elapsed;
		view    = '0;
		elapsed = stamp - prev_press_ms;
		if (kind == kcl_pkg::OP_KEY) begin
			if (!(key == prev_press && elapsed < {16'd0, guard_ms})) begin
				view.accepted = 1'b1;
				prev_press    = key;
				prev_press_ms = stamp;
				apply_key(key);
			end
		end else if (lock_mode == kcl_pkg::MODE_SHOW) begin
			if (hold_left != 0) begin
				hold_left--;
			end else begin
				lock_mode    = kcl_pkg::MODE_IDLE;
				view.expired = 1'b1;
			end
		end
		view.mode = lock_mode;
		case (lock_mode)
			kcl_pkg::MODE_SHOW:    view.message = shown_msg;
			kcl_pkg::MODE_ARMED:   view.message = kcl_pkg::MSG_CHANGE;
			kcl_pkg::MODE_NEWCODE: view.message = kcl_pkg::MSG_NEWCODE;
			default:               view.message = kcl_pkg::MSG_ENTER;
		endcase
		view.digits = 4'(entry_len);
		return view;
	endfunction

	function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_lock();
			predicted_views.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kcl_pkg::REG_REPEAT_GUARD: guard_ms   = cfg_data;
					kcl_pkg::REG_SHORT_HOLD:   short_hold = cfg_data;
					kcl_pkg::REG_LONG_HOLD:    long_hold  = cfg_data;
					kcl_pkg::REG_MIN_LENGTH:   min_len    = cfg_data[3:0];
					default: ;
				endcase
			end
			// compare before predicting so a result can never match its own transaction
			if (out_valid && !out_stall) begin
				if (predicted_views.size() == 0) begin
					$error("unexpected result: mode %0d message %0d", mode, message);
					errors++;
				end else begin
					oldest_view = predicted_views.pop_front();
					check_field("mode", oldest_view.mode, mode);
					check_field("message", oldest_view.message, message);
					check_field("digits_entered", oldest_view.digits, digits_entered);
					check_field("key_accepted", oldest_view.accepted, key_accepted);
					check_field("back_to_idle", oldest_view.expired, back_to_idle);
				end
			end
			if (in_valid && !in_stall)
				predicted_views.push_back(advance_lock(op, key_code, now_ms));
			outstanding = predicted_views.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
module testbench;

	localparam int MAX_DIGITS     = 12;
	localparam int HOLDOFF_CYCLES = 400;
	// a last run at the largest hold counts can never drain them, so cap the tick prefix
	localparam int SETTLE_CAP     = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        op        = kcl_pkg::OP_KEY;
	logic [7:0]  key_code  = '0;
	logic [31:0] now_ms    = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  mode;
	logic [2:0]  message;
	logic [3:0]  digits_entered;
	logic        key_accepted;
	logic        back_to_idle;

	int lock_errors;
	int lock_outstanding;

	// idling knobs for the current phase, in percent per cycle
	int gap_pct   = 0;
	int stall_pct = 0;

	// receiver hold-off used to back the pipeline up into the input
	bit   holdoff_req = 1'b0;
	logic holdoff     = 1'b0;

	// what the stimulus side believes about the lock, used only to shape sequences
	int          sent_total = 0;
	logic [31:0] clock_ms   = 32'hFFFF_FE00;
	int          guard_now  = kcl_pkg::RST_REPEAT_GUARD;
	int          short_now  = kcl_pkg::RST_SHORT_HOLD;
	int          long_now   = kcl_pkg::RST_LONG_HOLD;
	int          minlen_now = kcl_pkg::RST_MIN_LENGTH;
	int          believed_code [MAX_DIGITS];
	int          believed_len  = kcl_pkg::FACTORY_LENGTH;

	keypad_code_lock #(.MAX_CODE_DIGITS(MAX_DIGITS)) uut (.*);

	keypad_lock_checker #(.MAX_CODE_DIGITS(MAX_DIGITS)) lock_check (
		.*,
		.errors(lock_errors),
		.outstanding(lock_outstanding)
	);

	always #6 clk = ~clk;

	// Receiver: stall at random per phase, or solidly during the hold-off.
	always @(negedge clk) begin
		out_stall <= holdoff || ($urandom_range(99) < stall_pct);
	end

	// Hold-off: once requested, refuse results for HOLDOFF_CYCLES while the
	// sender keeps offering transactions, so the block fills and stalls its input.
	initial begin
		wait (holdoff_req);
		@(negedge clk);
		holdoff <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(negedge clk);
		holdoff <= 1'b0;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#24_000_000;
		$display("keypad_code_lock test failed");
		$finish;
	end

	function automatic logic [7:0] digit_key(int d);
		return 8'(kcl_pkg::KEY_ZERO + d);
	endfunction

	// Offer one transaction. Enter and leave at a falling edge; hold the payload
	// until the block takes it.
	task automatic send_item(logic kind, logic [7:0] key, logic [31:0] stamp);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		key_code <= key;
		now_ms   <= stamp;
		do @(posedge clk); while (in_stall);
		sent_total++;
		@(negedge clk);
	endtask

	// Press a key far enough after the last one that the repeat guard never drops it.
	task automatic press(logic [7:0] key);
		clock_ms += 32'(guard_now) + 1 + $urandom_range(40);
		send_item(kcl_pkg::OP_KEY, key, clock_ms);
	endtask

	// Step tick: key and time are don't-care here, so randomize them.
	task automatic tick();
		send_item(kcl_pkg::OP_TICK, 8'($urandom), $urandom());
	endtask

	// Ticks to let a message run out, capped at SETTLE_CAP.
	task automatic settle();
		int n;
		n = ((short_now > long_now) ? short_now : long_now) + 2;
		if (n > SETTLE_CAP)
			n = SETTLE_CAP;
		repeat (n) tick();
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (lock_outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Rewrite every register while the lock is quiet.
	task automatic configure(int guard, int short_h, int long_h, int minlen);
		drain_results();
		write_reg(kcl_pkg::REG_REPEAT_GUARD, 16'(guard));
		write_reg(kcl_pkg::REG_SHORT_HOLD, 16'(short_h));
		write_reg(kcl_pkg::REG_LONG_HOLD, 16'(long_h));
		// upper bits are junk; only the low nibble is kept
		write_reg(kcl_pkg::REG_MIN_LENGTH, {12'($urandom), 4'(minlen)});
		cfg_valid  <= 1'b0;
		guard_now  = guard;
		short_now  = short_h;
		long_now   = long_h;
		minlen_now = minlen;
	endtask

	// Unlock attempt: mostly the believed code, sometimes one digit off or pure junk.
	task automatic try_unlock();
		int pick;
		int bad_pos;
		int n;
		pick    = $urandom_range(99);
		bad_pos = $urandom_range(MAX_DIGITS - 1);
		settle();
		if (pick < 15) begin
			n = $urandom_range(0, 14);
			repeat (n) press(digit_key($urandom_range(9)));
		end else if (believed_len == 0) begin
			press(digit_key($urandom_range(9)));
		end else begin
			for (int i = 0; i < believed_len; i++) begin
				if (pick < 30 && i == bad_pos % believed_len)
					press(digit_key((believed_code[i] + 1) % 10));
				else
					press(digit_key(believed_code[i]));
			end
		end
		press(kcl_pkg::KEY_STAR);
	endtask

	// Code change: hash, star, some digits (past a full buffer at times), star.
	task automatic change_code();
		int n;
		int staged [MAX_DIGITS];
		int d;
		n = $urandom_range(0, 14);
		settle();
		press(kcl_pkg::KEY_HASH);
		press(kcl_pkg::KEY_STAR);
		for (int i = 0; i < n; i++) begin
			d = $urandom_range(9);
			if (i < MAX_DIGITS)
				staged[i] = d;
			press(digit_key(d));
		end
		press(kcl_pkg::KEY_STAR);
		if (n > MAX_DIGITS)
			n = MAX_DIGITS;
		if (n >= minlen_now) begin
			believed_code = staged;
			believed_len  = n;
		end
	endtask

	// Same key hammered at spacings on both sides of the guard window.
	task automatic guard_burst();
		logic [7:0] key;
		case ($urandom_range(3))
			0: key = kcl_pkg::KEY_HASH;
			1: key = kcl_pkg::KEY_STAR;
			2: key = 8'($urandom);
			default: key = digit_key($urandom_range(9));
		endcase
		repeat ($urandom_range(2, 5)) begin
			clock_ms += $urandom_range(0, 2 * guard_now + 2);
			send_item(kcl_pkg::OP_KEY, key, clock_ms);
		end
	endtask

	// Junk: any kind, any key code, times that creep or jump anywhere.
	task automatic noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(9) == 0)
				clock_ms = $urandom();
			else
				clock_ms += $urandom_range(0, 400);
			send_item(1'($urandom), 8'($urandom), clock_ms);
		end
	endtask

	task automatic run_random(int target);
		int pick;
		while (sent_total < target) begin
			// back the block up once, early, while the sender never idles
			if (!holdoff_req && sent_total >= 200)
				holdoff_req = 1'b1;
			pick = $urandom_range(99);
			if (pick < 35)
				try_unlock();
			else if (pick < 55)
				change_code();
			else if (pick < 70)
				guard_burst();
			else
				noise();
		end
	endtask

	task automatic set_idling(int gap, int stall);
		gap_pct   = gap;
		stall_pct <= stall;
	endtask

	initial begin
		for (int i = 0; i < MAX_DIGITS; i++)
			believed_code[i] = i + 1;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk through each mode and corner, short holds.
		configure(100, 1, 0, 4);
		tick();                                  // tick while idle
		press(kcl_pkg::KEY_STAR);                // star in idle: ignored
		press(8'h41);                            // unused key: guard only
		for (int i = 1; i <= kcl_pkg::FACTORY_LENGTH; i++)
			press(digit_key(i));                 // factory code
		press(kcl_pkg::KEY_STAR);                // OK
		press(digit_key(3));                     // digit while showing
		press(kcl_pkg::KEY_STAR);                // star while showing
		tick();                                  // hold 1 -> 0
		tick();                                  // expire to idle
		press(digit_key(9));                     // start entry
		press(kcl_pkg::KEY_HASH);                // arm from entry, buffer kept
		press(digit_key(5));                     // digit while armed: ignored
		press(kcl_pkg::KEY_STAR);                // new-code entry
		press(kcl_pkg::KEY_HASH);                // arm again from new-code entry
		press(kcl_pkg::KEY_STAR);
		press(digit_key(2));
		clock_ms += 10;
		send_item(kcl_pkg::OP_KEY, digit_key(2), clock_ms);   // repeat inside the guard: dropped
		press(kcl_pkg::KEY_STAR);                // too short: bad length
		tick();                                  // zero hold: expire at once
		press(8'hFF);
		press(8'h00);

		// No idling anywhere; the hold-off lands here.
		configure(200, 0, 3, 1);
		set_idling(0, 0);
		run_random(470);

		// Sender idles a lot; guard off, longest code required.
		configure(0, 2, 0, 12);
		set_idling(82, 0);
		run_random(910);

		// Receiver stalls a lot; widest guard, empty code allowed.
		configure(65535, 1, 1, 0);
		set_idling(0, 82);
		run_random(1350);

		// Light idling both ways; minimum length beyond the buffer.
		configure(1000, 3, 4, 15);
		set_idling(18, 18);
		run_random(1750);

		// Largest holds: messages stick, keys still go through the guard.
		configure(65535, 65535, 65535, 8);
		set_idling(0, 0);
		run_random(1790);

		drain_results();
		if (lock_errors == 0 && lock_outstanding == 0)
			$display("keypad_code_lock test passed");
		else
			$display("keypad_code_lock test failed");
		$finish;
	end

endmodule
